// File: rtl/ilpf_pkg.sv
// ----------------------------------------------------------------------------
// ilpf_pkg
// Shared types and constants of the interval-sampled low-pass filter.
// ----------------------------------------------------------------------------
package ilpf_pkg;

  localparam int TIME_W   = 32;
  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 20;
  localparam int REG_W    = 16;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;
  localparam int DEN_W    = TIME_W + 1;
  localparam int NUM_W    = 64;

  localparam logic [VALUE_W-1:0] VALUE_MAX       = '1;
  localparam logic [REG_W-1:0]   READ_INTERVAL_RST = 16'd1000;
  localparam logic [REG_W-1:0]   FILTER_TIME_RST   = 16'd0;

  typedef enum logic [0:0] {
    REG_READ_INTERVAL = 1'b0,
    REG_FILTER_TIME   = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

// File: rtl/ilpf_if.sv
// ----------------------------------------------------------------------------
// ilpf_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ilpf_in_if import ilpf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TIME_W-1:0]   now_ms;
  logic [SAMPLE_W-1:0] sample_quarter_deg;

  modport source (output valid, now_ms, sample_quarter_deg, input ready);
  modport sink   (input valid, now_ms, sample_quarter_deg, output ready);
endinterface

interface ilpf_out_if import ilpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] filtered_value;
  logic               updated;

  modport source (output valid, filtered_value, updated, input ready);
  modport sink   (input valid, filtered_value, updated, output ready);
endinterface

// File: rtl/ilpf_div.sv
// ----------------------------------------------------------------------------
// ilpf_div
// Restoring divider, one quotient bit per cycle. The quotient must fit
// in QW bits.
// ----------------------------------------------------------------------------
module ilpf_div import ilpf_pkg::*; #(
  parameter int QW = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QW-1:0]    quot_o
);

  localparam int CW = (QW > 1) ? $clog2(QW) : 1;

  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [QW-1:0]    lo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, lo_q[QW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(QW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[QW +: DEN_W];
      lo_q  <= num_i[QW-1:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      lo_q  <= {lo_q[QW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = lo_q;

endmodule

// File: rtl/interval_sampled_lowpass_filter_unit.sv
// ----------------------------------------------------------------------------
// interval_sampled_lowpass_filter_unit
// First-order low-pass over a millisecond-stamped thermocouple reading.
// ----------------------------------------------------------------------------
// One item at a time: the input is not ready again until the result has been
// transferred. The first item after reset goes straight to the result. An item
// that stays below the read interval, or takes the sample directly (zero filter
// time and zero elapsed time), passes a check state first. A filtered item also
// passes the shared 32x32 multiplier used twice and the bit-serial divider that
// produces one quotient bit per cycle, for max(20, 12+FRACTION_BITS) bits. A
// stalled result holds the unit in its output state. Registers at 0x0 (read
// interval) and 0x4 (filter time); the user must write them over APB only while
// idle, which the block itself does not enforce.
module interval_sampled_lowpass_filter_unit import ilpf_pkg::*; #(
  parameter int FRACTION_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  ilpf_in_if.sink           in_i,
  ilpf_out_if.source        out_o
);

  localparam int SW = SAMPLE_W + FRACTION_BITS;
  localparam int QW = (SW > VALUE_W) ? SW : VALUE_W;
  localparam logic [QW-1:0] VMAX = QW'(VALUE_MAX);

  ctrl_state_e state_q, state_d;

  logic [REG_W-1:0]    ri_q;
  logic [REG_W-1:0]    ft_q;
  logic                started_q;
  logic [TIME_W-1:0]   last_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic [VALUE_W-1:0]  value_q;
  logic                upd_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [NUM_W-1:0]    prod_q;
  logic [NUM_W-1:0]    acc_q;
  logic [DEN_W-1:0]    den_q;

  logic                in_xfer;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;
  logic [TIME_W:0]     el_sum;
  logic [QW-1:0]       samp_w;
  logic [DEN_W-1:0]    den_w;
  logic [TIME_W-1:0]   mul_a;
  logic [TIME_W-1:0]   mul_b;
  logic [NUM_W-1:0]    mul_p;
  logic [QW-1:0]       quot;
  div_ctl_t            div_ctl;

  function automatic logic [VALUE_W-1:0] sat_value(input logic [QW-1:0] v);
    sat_value = (v > VMAX) ? VALUE_MAX : v[VALUE_W-1:0];
  endfunction

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      REG_READ_INTERVAL: prdata = APB_DW'(ri_q);
      REG_FILTER_TIME:   prdata = APB_DW'(ft_q);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= READ_INTERVAL_RST;
      ft_q <= FILTER_TIME_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_READ_INTERVAL: ri_q <= pwdata[REG_W-1:0];
        REG_FILTER_TIME:   ft_q <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign in_xfer              = in_i.valid && in_i.ready;
  assign in_i.ready           = (state_q == ST_IDLE);
  assign out_o.valid          = (state_q == ST_OUT);
  assign out_o.filtered_value = value_q;
  assign out_o.updated        = upd_q;

  // datapath
  assign el_sum = {1'b0, elapsed_q} + {1'b0, in_i.now_ms - last_q};
  assign samp_w = QW'(sample_q) << FRACTION_BITS;
  assign den_w  = DEN_W'(ft_q) + DEN_W'(elapsed_q);

  always_comb begin
    unique case (state_q)
      ST_MUL_A: begin
        mul_a = TIME_W'(value_q);
        mul_b = TIME_W'(ft_q);
      end
      default: begin
        mul_a = TIME_W'(samp_w);
        mul_b = elapsed_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign div_ctl.start = (state_q == ST_SUM);

  ilpf_div #(
    .QW(QW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_ctl.start),
    .num_i  (acc_q + prod_q),
    .den_i  (den_q),
    .done_o (div_ctl.done),
    .quot_o (quot)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = started_q ? ST_CHECK : ST_OUT;
      ST_CHECK: begin
        if (elapsed_q < TIME_W'(ri_q)) begin
          state_d = ST_OUT;
        end else if (den_w == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_SUM;
      ST_SUM:   state_d = ST_DIV;
      ST_DIV:   if (div_ctl.done) state_d = ST_OUT;
      ST_OUT:   if (out_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
      elapsed_q <= '0;
      value_q   <= '0;
      upd_q     <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            started_q <= 1'b1;
            last_q    <= in_i.now_ms;
            upd_q     <= 1'b0;
            if (started_q) begin
              elapsed_q <= el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
            end
          end
        end
        ST_CHECK: begin
          if (elapsed_q >= TIME_W'(ri_q) && den_w == '0) begin
            value_q   <= sat_value(samp_w);
            elapsed_q <= '0;
            upd_q     <= 1'b1;
          end
        end
        ST_DIV: begin
          if (div_ctl.done) begin
            value_q   <= sat_value(quot);
            elapsed_q <= '0;
            upd_q     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= in_i.sample_quarter_deg;
    end
    if (state_q == ST_CHECK) begin
      den_q <= den_w;
    end
    if (state_q == ST_MUL_A || state_q == ST_MUL_B) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_MUL_B) begin
      acc_q <= prod_q;
    end
  end

endmodule
